// File: rtl/core/utf8_stream_decoder_defines.svh
// Assertion macros for the UTF-8 stream decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UTF8SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/utf8sd_pkg.sv
// Types and constants for the UTF-8 stream decoder.
// No dependencies.
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned BUF_PTR_W = 2;
  localparam int unsigned BUF_CNT_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LATIN1_MODE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_POINT = 1'd1;

  localparam logic [CP_W-1:0] REPLACEMENT_RESET = 21'h00FFFD;

  localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
  localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            last_of_run;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/utf8_stream_decoder.sv
// UTF-8 / Latin-1 byte stream to code point decoder, top level.
// Depends on utf8sd_pkg and utf8_stream_decoder_defines.svh.
//
//   channel | direction | tdata                 | tuser          | tlast
//   in_     | slave     | byte_value [7:0]      | -              | last_of_string
//   out_    | master    | code_point [20:0]     | is_replacement | last_of_run
//   cfg_    | write     | index 0 latin1_mode, index 1 replacement_point
//
// One byte is accepted per cycle while in_tready is high; decoding is done in the accept cycle.
// A byte yields zero, one or two results; results leave one per output transfer.
// Results wait in a four-entry buffer; in_tready drops with more than two queued.
// Synchronous active-low reset clears decoder state, resets the registers and empties the buffer.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // [7:0] byte_value
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [20:0] code_point, [23:21] zero
  output logic                       out_tuser,  // [0] is_replacement
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CP_W-1:0]       cfg_wdata
);

  logic            latin1_r;
  logic [CP_W-1:0] repl_r;
  logic [1:0]      pend_r, pend_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;

  result_t              buf_r [BUF_DEPTH];
  logic [BUF_PTR_W-1:0] wptr_r, rptr_r;
  logic [BUF_CNT_W-1:0] cnt_r, cnt_nxt;

  result_t     res0, res1;
  logic [1:0]  n_res;
  logic        in_fire, out_fire;
  logic [BYTE_W-1:0] c;

  assign c         = in_tdata;
  assign in_tready = (cnt_r <= BUF_CNT_W'(BUF_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_fire  = out_tvalid && out_tready;

  always_comb begin
    logic [1:0]      n;
    logic [CP_W-1:0] cp0, cp1;
    logic            err0, err1;
    n        = 2'd0;
    cp0      = '0;
    cp1      = '0;
    err0     = 1'b0;
    err1     = 1'b0;
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    if (latin1_r) begin
      pend_nxt = 2'd0;
      acc_nxt  = '0;
      cp0      = CP_W'(c);
      n        = 2'd1;
    end else if (c <= ASCII_MAX) begin
      if (pend_r != 2'd0) begin
        cp0      = repl_r;
        err0     = 1'b1;
        cp1      = CP_W'(c);
        n        = 2'd2;
        pend_nxt = 2'd0;
      end else begin
        cp0 = CP_W'(c);
        n   = 2'd1;
      end
    end else if (c <= CONT_MAX) begin
      if (pend_r != 2'd0) begin
        acc_nxt  = {acc_r[CP_W-7:0], c[5:0]};
        pend_nxt = pend_r - 2'd1;
        if (pend_nxt == 2'd0) begin
          cp0 = acc_nxt;
          n   = 2'd1;
        end
      end else begin
        cp0  = repl_r;
        err0 = 1'b1;
        n    = 2'd1;
      end
    end else if (c <= LEAD2_MAX) begin
      pend_nxt = 2'd1;
      acc_nxt  = CP_W'(c & 8'h1F);
    end else if (c <= LEAD3_MAX) begin
      pend_nxt = 2'd2;
      acc_nxt  = CP_W'(c & 8'h0F);
    end else if (c <= LEAD4_MAX) begin
      pend_nxt = 2'd3;
      acc_nxt  = CP_W'(c & 8'h07);
    end else begin
      cp0      = repl_r;
      err0     = 1'b1;
      n        = 2'd1;
      pend_nxt = 2'd0;
    end
    if (in_tlast) begin
      if (pend_nxt != 2'd0) begin
        if (n == 2'd0) begin
          cp0  = repl_r;
          err0 = 1'b1;
        end else begin
          cp1  = repl_r;
          err1 = 1'b1;
        end
        n = n + 2'd1;
      end
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
    n_res = n;
    res0  = '{code_point: cp0, is_replacement: err0, last_of_run: (n == 2'd1)};
    res1  = '{code_point: cp1, is_replacement: err1, last_of_run: (n == 2'd2)};
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = cnt_nxt + BUF_CNT_W'(n_res);
    end
    if (out_fire) begin
      cnt_nxt = cnt_nxt - BUF_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latin1_r <= 1'b0;
      repl_r   <= REPLACEMENT_RESET;
      pend_r   <= 2'd0;
      acc_r    <= '0;
      wptr_r   <= '0;
      rptr_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LATIN1_MODE:       latin1_r <= cfg_wdata[0];
          REG_REPLACEMENT_POINT: repl_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        pend_r <= pend_nxt;
        acc_r  <= acc_nxt;
        wptr_r <= wptr_r + BUF_PTR_W'(n_res);
      end
      if (out_fire) begin
        rptr_r <= rptr_r + BUF_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (n_res != 2'd0) begin
        buf_r[wptr_r] <= res0;
      end
      if (n_res == 2'd2) begin
        buf_r[wptr_r + BUF_PTR_W'(1)] <= res1;
      end
    end
  end

  result_t head;
  assign head       = buf_r[rptr_r];
  assign out_tdata  = OUT_DATA_W'(head.code_point);
  assign out_tuser  = head.is_replacement;
  assign out_tlast  = head.last_of_run;

  `UTF8SD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= BUF_CNT_W'(BUF_DEPTH), "result buffer overflow")
  `UTF8SD_ASSERT_NEXT(a_latin1_clears, in_fire && latin1_r, pend_r == 2'd0, "latin1 left pending")
  `UTF8SD_ASSERT_NEXT(a_last_clears, in_fire && in_tlast, pend_r == 2'd0 && acc_r == '0, "string end left state")
  `UTF8SD_ASSERT_NEXT(a_cnt_hold, !in_fire && !out_fire, $stable(cnt_r) && $stable(rptr_r), "buffer moved while idle")
  `UTF8SD_ASSERT_NOW(a_ptr_track, 1'b1, BUF_PTR_W'(wptr_r - rptr_r) == BUF_PTR_W'(cnt_r), "pointer count mismatch")

endmodule

`default_nettype wire
